/* design/tcst_pkg.sv */
// Shared types, constants and codes for the touch contact slot table.
// No dependencies.
package tcst_pkg;

	localparam int SLOT_MAX    = 16;
	localparam int CONTACT_MAX = 10;
	localparam int SLOT_W      = 5;
	localparam int IDX_W       = 4;
	localparam int CNT_W       = 4;
	localparam logic [14:0] TOUCH_X_MAX = 15'd32767;
	localparam logic [14:0] TOUCH_Y_MAX = 15'd32767;
	localparam logic [15:0] NO_ID = 16'hFFFF;

	localparam logic [1:0] OP_FILL    = 2'd0;
	localparam logic [1:0] OP_RESERVE = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;
	localparam logic [1:0] OP_SYNC    = 2'd3;

	localparam logic [2:0] REG_SLOT_COUNT    = 3'd0;
	localparam logic [2:0] REG_CONTACT_COUNT = 3'd1;
	localparam logic [2:0] REG_HDMI_MODE     = 3'd2;
	localparam logic [2:0] REG_SWAP_AXES     = 3'd3;
	localparam logic [2:0] REG_ROTATE_HALF   = 3'd4;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] touch_id;
		logic        active;
		logic signed [15:0] x_pos;
		logic signed [15:0] y_pos;
		logic        link_accept;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic        ok;
		logic [4:0]  slot_index;
		logic        tip;
		logic        proximity;
		logic [4:0]  contact_ident;
		logic [14:0] out_x;
		logic [14:0] out_y;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [15:0] touch_id;
		logic        tip;
		logic        proximity;
		logic [3:0]  ident;
		logic [14:0] x;
		logic [14:0] y;
	} slot_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture input word
		logic init;        // clear tables
		logic scan_clr;    // restart scan index
		logic scan_adv;    // advance scan index
		logic fill_find;   // fill: test current slot for id match
		logic fill_free;   // fill: test current slot free
		logic fill_apply;  // fill: update chosen slot
		logic reserve;     // reserve step
		logic clear_step;  // clear-all step on scan slot
		logic sync_test;   // compare slot/shadow at scan
		logic emit;        // present report/status word
		logic commit_step; // commit at slot just below scan index
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;
		logic match;
		logic is_free;
		logic found;
		logic picks_full;
		logic picks_none;
		logic emit_last;
	} dp_stat_t;

endpackage

/* design/tcst_datapath.sv */
// Datapath of the slot table: slot and shadow registers, scan index, pick list.
// Depends on tcst_pkg.
module tcst_datapath (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [4:0] cfg_data,
	input  tcst_pkg::in_word_t in_word,
	input  tcst_pkg::dp_cmd_t cmd,
	output tcst_pkg::dp_stat_t stat,
	output tcst_pkg::out_word_t out_word
);
	import tcst_pkg::*;

	slot_t slot_q [SLOT_MAX];
	slot_t shadow_q [SLOT_MAX];
	logic [4:0] slot_count_q, dyn_low_q, dyn_high_q;
	logic [3:0] contact_count_q;
	logic hdmi_q, swap_q, rot_q;
	in_word_t req_q;
	logic [4:0] scan_q;
	logic [4:0] chosen_q;
	logic found_q, ok_q;
	logic [3:0] picked_q [CONTACT_MAX];
	logic [3:0] npick_q, emit_q;

	logic [3:0] cc;
	logic [3:0] si;
	logic [4:0] scan_prev;
	logic [4:0] scan_lim_hi;
	logic [14:0] cx, cy;
	slot_t cur, pe;
	logic [15:0] tx, ty;

	assign cc = (contact_count_q == 4'd0) ? 4'd1 : contact_count_q;
	assign si = scan_q[3:0];
	assign scan_prev = scan_q - 5'd1;
	assign cur = slot_q[si];

	always_comb begin
		if (req_q.x_pos < 0) cx = '0;
		else if (req_q.x_pos > $signed({1'b0, TOUCH_X_MAX})) cx = TOUCH_X_MAX;
		else cx = req_q.x_pos[14:0];
		if (req_q.y_pos < 0) cy = '0;
		else if (req_q.y_pos > $signed({1'b0, TOUCH_Y_MAX})) cy = TOUCH_Y_MAX;
		else cy = req_q.y_pos[14:0];
	end

	// scan bound: fill scans dynamic range, others slot_count
	assign scan_lim_hi = (req_q.opcode == OP_FILL) ? dyn_high_q : slot_count_q;

	assign stat.scan_end   = (scan_q >= scan_lim_hi) || (scan_q >= 5'(SLOT_MAX));
	assign stat.match      = (req_q.touch_id != NO_ID) && (cur.touch_id == req_q.touch_id);
	assign stat.is_free    = cur.touch_id == NO_ID;
	assign stat.found      = found_q;
	assign stat.picks_full = npick_q >= cc;
	assign stat.picks_none = npick_q == 4'd0;
	assign stat.emit_last  = (emit_q + 4'd1) == cc;

	assign pe = slot_q[picked_q[emit_q]];
	always_comb begin
		tx = {1'b0, pe.x};
		ty = {1'b0, pe.y};
		if (hdmi_q ^ swap_q) begin
			tx = {1'b0, pe.y};
			ty = {1'b0, TOUCH_Y_MAX} - {1'b0, pe.x};
		end
		if (rot_q) begin
			tx = {1'b0, TOUCH_X_MAX} - tx;
			ty = {1'b0, TOUCH_Y_MAX} - ty;
		end
	end

	always_comb begin
		out_word = '0;
		out_word.slot_index = 5'(SLOT_MAX);
		out_word.last = 1'b1;
		if (req_q.opcode == OP_SYNC && !stat.picks_none) begin
			out_word.kind = 1'b1;
			out_word.ok = req_q.link_accept;
			out_word.last = stat.emit_last;
			if (emit_q < npick_q) begin
				out_word.tip = pe.tip;
				out_word.proximity = pe.proximity;
				out_word.contact_ident = {1'b0, pe.ident} + 5'd1;
				out_word.out_x = tx[15] ? '0 : tx[14:0];
				out_word.out_y = ty[15] ? '0 : ty[14:0];
			end
		end else if (req_q.opcode == OP_SYNC) begin
			out_word.ok = 1'b1;
		end else begin
			out_word.ok = ok_q;
			if (req_q.opcode != OP_CLEAR) out_word.slot_index = chosen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= 5'(SLOT_MAX);
			contact_count_q <= 4'(CONTACT_MAX);
			hdmi_q <= 1'b0;
			swap_q <= 1'b0;
			rot_q <= 1'b0;
			dyn_low_q <= '0;
			dyn_high_q <= 5'(SLOT_MAX);
			for (int i = 0; i < SLOT_MAX; i++) begin
				slot_q[i] <= '{touch_id: NO_ID, default: '0};
				shadow_q[i] <= '{touch_id: NO_ID, default: '0};
			end
			req_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
			ok_q <= 1'b0;
			chosen_q <= 5'(SLOT_MAX);
			npick_q <= '0;
			emit_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_SLOT_COUNT: begin
					slot_count_q <= (cfg_data > 5'(SLOT_MAX)) ? 5'(SLOT_MAX) : cfg_data;
					dyn_low_q <= '0;
					dyn_high_q <= (cfg_data > 5'(SLOT_MAX)) ? 5'(SLOT_MAX) : cfg_data;
					for (int i = 0; i < SLOT_MAX; i++) begin
						slot_q[i] <= '{touch_id: NO_ID, default: '0};
						shadow_q[i] <= '{touch_id: NO_ID, default: '0};
					end
				end
				REG_CONTACT_COUNT: contact_count_q <=
					(cfg_data[3:0] > 4'(CONTACT_MAX)) ? 4'(CONTACT_MAX) : cfg_data[3:0];
				REG_HDMI_MODE: hdmi_q <= cfg_data[0];
				REG_SWAP_AXES: swap_q <= cfg_data[0];
				REG_ROTATE_HALF: rot_q <= cfg_data[0];
				default: ;
				endcase
			end
			if (cmd.load) begin
				req_q <= in_word;
				found_q <= 1'b0;
				ok_q <= 1'b0;
				chosen_q <= 5'(SLOT_MAX);
				npick_q <= '0;
				emit_q <= '0;
			end
			if (cmd.scan_clr)
				scan_q <= ((cmd.load ? in_word.opcode : req_q.opcode) == OP_FILL) ?
					dyn_low_q : '0;
			if (cmd.scan_adv) scan_q <= scan_q + 5'd1;
			if (cmd.fill_find && stat.match) begin
				found_q <= 1'b1;
				chosen_q <= scan_q;
			end
			if (cmd.fill_free && stat.is_free && req_q.touch_id != NO_ID) begin
				found_q <= 1'b1;
				chosen_q <= scan_q;
				slot_q[si].touch_id <= req_q.touch_id;
			end
			if (cmd.fill_apply && found_q) begin
				logic chg;
				slot_t e;
				e = slot_q[chosen_q[3:0]];
				if (req_q.active) chg = e.tip ? (e.x != cx || e.y != cy) : 1'b1;
				else chg = e.tip;
				ok_q <= chg;
				if (chg) begin
					slot_q[chosen_q[3:0]].proximity <= 1'b1;
					slot_q[chosen_q[3:0]].ident <= chosen_q[3:0];
					slot_q[chosen_q[3:0]].tip <= req_q.active;
					if (req_q.active) begin
						slot_q[chosen_q[3:0]].x <= cx;
						slot_q[chosen_q[3:0]].y <= cy;
					end
				end
			end
			if (cmd.reserve) begin
				logic [4:0] s;
				s = 5'(SLOT_MAX);
				if (req_q.active) begin
					if (dyn_low_q < dyn_high_q && dyn_low_q < 5'(SLOT_MAX)) begin
						s = dyn_low_q;
						dyn_low_q <= dyn_low_q + 5'd1;
					end
				end else if (dyn_high_q > dyn_low_q) begin
					s = dyn_high_q - 5'd1;
					dyn_high_q <= dyn_high_q - 5'd1;
				end
				chosen_q <= s;
				ok_q <= s < 5'(SLOT_MAX);
				if (s < 5'(SLOT_MAX)) begin
					if (slot_q[s[3:0]].tip) begin
						slot_q[s[3:0]].proximity <= 1'b1;
						slot_q[s[3:0]].ident <= s[3:0];
						slot_q[s[3:0]].tip <= 1'b0;
					end
					slot_q[s[3:0]].touch_id <= req_q.touch_id;
				end
			end
			if (cmd.clear_step && cur.tip) begin
				slot_q[si].proximity <= 1'b1;
				slot_q[si].ident <= si;
				slot_q[si].tip <= 1'b0;
				ok_q <= 1'b1;
			end
			if (cmd.sync_test && (slot_q[si] != shadow_q[si])) begin
				picked_q[npick_q] <= si;
				npick_q <= npick_q + 4'd1;
			end
			if (cmd.emit) emit_q <= emit_q + 4'd1;
			if (cmd.commit_step) begin
				slot_t n;
				n = slot_q[scan_prev[3:0]];
				if (!n.tip) begin
					n = '{touch_id: NO_ID, default: '0};
					if (!(scan_prev >= dyn_low_q && scan_prev < dyn_high_q))
						n.touch_id = slot_q[scan_prev[3:0]].touch_id;
				end
				slot_q[scan_prev[3:0]] <= n;
				shadow_q[scan_prev[3:0]] <= n;
				scan_q <= scan_prev;
			end
		end
	end

	a_pick_count: assert property (@(posedge clk) disable iff (!arst_n)
		npick_q <= 4'(CONTACT_MAX))
		else $error("pick count beyond contact maximum");
	a_dyn_order: assert property (@(posedge clk) disable iff (!arst_n)
		dyn_low_q <= dyn_high_q)
		else $error("dynamic range inverted");
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.fill_apply && cmd.commit_step))
		else $error("conflicting slot updates");
endmodule

/* design/tcst_ctrl.sv */
// Controller state machine of the slot table.
// Depends on tcst_pkg.
module tcst_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  tcst_pkg::in_word_t in_word,
	output logic out_valid,
	input  logic out_ready,
	input  tcst_pkg::dp_stat_t stat,
	output tcst_pkg::dp_cmd_t cmd
);
	import tcst_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FIND   = 3'd1;
	localparam logic [2:0] ST_FREE   = 3'd2;
	localparam logic [2:0] ST_APPLY  = 3'd3;
	localparam logic [2:0] ST_ONE    = 3'd4;
	localparam logic [2:0] ST_SCAN   = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;
	localparam logic [2:0] ST_COMMIT = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] op_q;

	// a free slot is only taken on a press; link acceptance is held for commit
	logic act_q, link_ok_q, scan_zero;
	logic [4:0] cnt_q;
	function automatic logic in_word_active();
		return act_q;
	endfunction
	assign scan_zero = cnt_q == 5'd0;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		out_valid = 1'b0;
		case (state_q)
		ST_IDLE: if (in_valid) begin
			cmd.load = 1'b1;
			cmd.scan_clr = 1'b1;
			case (in_word.opcode)
			OP_FILL: state_d = ST_FIND;
			OP_RESERVE: state_d = ST_ONE;
			default: state_d = ST_SCAN;
			endcase
		end
		ST_FIND: begin
			if (stat.scan_end || stat.match) begin
				cmd.fill_find = !stat.scan_end;
				cmd.scan_clr = 1'b1;
				state_d = (stat.match && !stat.scan_end) ? ST_APPLY : ST_FREE;
			end else begin
				cmd.scan_adv = 1'b1;
			end
		end
		ST_FREE: begin
			if (stat.scan_end || stat.is_free) begin
				cmd.fill_free = !stat.scan_end && in_word_active();
				state_d = ST_APPLY;
				if (!in_word_active()) state_d = ST_APPLY;
			end else begin
				cmd.scan_adv = 1'b1;
			end
		end
		ST_APPLY: begin
			cmd.fill_apply = 1'b1;
			state_d = ST_EMIT;
		end
		ST_ONE: begin
			cmd.reserve = 1'b1;
			state_d = ST_EMIT;
		end
		ST_SCAN: begin
			if (stat.scan_end || (op_q == OP_SYNC && stat.picks_full)) begin
				state_d = ST_EMIT;
			end else begin
				cmd.clear_step = op_q == OP_CLEAR;
				cmd.sync_test = op_q == OP_SYNC;
				cmd.scan_adv = 1'b1;
			end
		end
		ST_EMIT: begin
			out_valid = 1'b1;
			if (out_ready) begin
				cmd.emit = 1'b1;
				if (op_q != OP_SYNC || stat.picks_none) state_d = ST_IDLE;
				else if (stat.emit_last) state_d = ST_COMMIT;
			end
		end
		ST_COMMIT: begin
			if (!link_ok_q || scan_zero) state_d = ST_IDLE;
			else begin
				cmd.commit_step = 1'b1;
				cmd.scan_adv = 1'b0;
				state_d = ST_COMMIT;
			end
		end
		default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_FILL;
			act_q <= 1'b0;
			link_ok_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				op_q <= in_word.opcode;
				act_q <= in_word.active;
				link_ok_q <= in_word.link_accept;
				cnt_q <= '0;
			end
			if (cmd.scan_adv && state_q == ST_SCAN) cnt_q <= cnt_q + 5'd1;
			if (cmd.commit_step) cnt_q <= cnt_q - 5'd1;
		end
	end

	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && in_ready))
		else $error("output while idle");
	a_commit_link: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.commit_step && !link_ok_q))
		else $error("commit without link acceptance");
	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.fill_apply, cmd.reserve, cmd.clear_step,
			cmd.sync_test, cmd.commit_step}) <= 1)
		else $error("several datapath updates at once");
endmodule

/* design/touch_contact_slot_table.sv */
// Top level of the touch contact slot table: controller and datapath.
// Depends on tcst_pkg, tcst_ctrl, tcst_datapath.
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | in_word (in_word_t)
//  out     | out_valid / out_ready  | out_word (out_word_t)
//  cfg     | cfg_we                 | cfg_index, cfg_data
// One word at a time. Fill scans for a matching id, then for a free slot, then
// applies the update; reserve updates one slot; clear all and sync scan the
// slots, and sync then sends its report words and, if the link accepted,
// commits the scanned slots.
// Reset clears table, shadow and registers at once. A stalled output holds
// the block; no new word is taken until the last result word leaves and any commit ends.
module touch_contact_slot_table (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  tcst_pkg::in_word_t in_word,
	output logic out_valid,
	input  logic out_ready,
	output tcst_pkg::out_word_t out_word,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [4:0] cfg_data
);
	import tcst_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;

	tcst_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_word,
		.out_valid, .out_ready, .stat, .cmd
	);

	tcst_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_word, .cmd, .stat, .out_word
	);
endmodule
